### src/rbma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbma_pkg
// Shared widths, codes, types and defaults for the ring buffer moving
// average block.
// ----------------------------------------------------------------------------
package rbma_pkg;

    localparam int CMD_W     = 1;
    localparam int CH_W      = 3;
    localparam int VAL_W     = 32;
    localparam int AVG_W     = 32;
    localparam int FILL_W    = 5;
    localparam int WL_W      = 5;
    localparam int SUM_W     = 36;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int DEF_DEPTH    = 16;
    localparam int DEF_CHANNELS = 8;

    localparam logic [WL_W-1:0] WL_RESET = 5'd16;

    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = SUM_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CTX,
        S_UPD,
        S_DIV,
        S_FIN
    } fsm_state_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [FILL_W-1:0] head;
        logic [FILL_W-1:0] fill;
    } ctx_t;

endpackage
`default_nettype wire

### src/rbma_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbma_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/rbma_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbma_div
// Restoring divider, running sum by fill level, DIV_BITS quotient bits per
// cycle. The quotient is valid on the output in the cycle done is high.
// ----------------------------------------------------------------------------
module rbma_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rbma_pkg::SUM_W-1:0]  dividend,
    input  wire logic [rbma_pkg::FILL_W-1:0] divisor,
    output logic                            done,
    output logic      [rbma_pkg::SUM_W-1:0]  quotient
);
    import rbma_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [SUM_W-1:0]     acc_next;
    logic [FILL_W-1:0]    rem_reg;
    logic [FILL_W-1:0]    rem_next;
    logic [FILL_W-1:0]    den_reg;

    always_comb
    begin
        logic [FILL_W:0]    trial;
        logic [SUM_W-1:0]   acc;
        logic [FILL_W-1:0]  rem;
        acc = acc_reg;
        rem = rem_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial = {rem, acc[SUM_W-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem = FILL_W'(trial - {1'b0, den_reg});
                acc = {acc[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem = trial[FILL_W-1:0];
                acc = {acc[SUM_W-2:0], 1'b0};
            end
        end
        acc_next = acc;
        rem_next = rem;
    end

    assign done     = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign quotient = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule
`default_nettype wire

### src/ring_buffer_moving_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_moving_average
// Per-channel moving average over a ring of recent samples.
// ----------------------------------------------------------------------------
// One item is taken at a time. A push passes through these states in order:
// S_CTX reads the channel context memory, S_UPD reads the oldest sample and
// writes back sample and context, S_DIV runs the divider that retires four
// quotient bits of the 36-bit running sum per cycle, S_FIN loads the output
// register, and S_IDLE accepts the next beat. A clear or an item for a
// channel of CHANNELS or more skips S_UPD and S_DIV. The result sits in an
// output register, so the next item is accepted while it waits; a result
// still held there stalls the following item at its output load step until
// the beat is taken. The user must write the window_length register only
// while idle, which the block does not enforce; clear every channel after changing it.
// ----------------------------------------------------------------------------
module ring_buffer_moving_average #(
    parameter int DEPTH    = rbma_pkg::DEF_DEPTH,
    parameter int CHANNELS = rbma_pkg::DEF_CHANNELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config
    input  wire logic                          cfg_we,
    input  wire logic [rbma_pkg::WL_W-1:0]      cfg_wdata,
    // input beats
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rbma_pkg::S_TDATA_W-1:0] s_tdata,  // channel[2:0], value[34:3]
    input  wire logic                          s_tuser,  // command
    // result beats
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [rbma_pkg::M_TDATA_W-1:0] m_tdata,  // average[31:0], fill_count[36:32]
    output logic                               m_tuser   // status
);
    import rbma_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = (CHANNELS * DEPTH > 1) ? $clog2(CHANNELS * DEPTH) : 1;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic [WL_W-1:0]   wl_reg;
    logic              cmd_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              full_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [FILL_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [AW-1:0]     addr_reg;
    logic [AVG_W-1:0]  res_avg_reg;
    logic              res_empty_reg;
    logic [CHANNELS-1:0] ctx_vld_reg;

    logic              out_valid_reg;
    logic [AVG_W-1:0]  out_avg_reg;
    logic              out_st_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic              in_acc;
    logic [CH_W-1:0]   in_ch;
    logic [VAL_W-1:0]  in_val;
    logic              ch_ok;
    logic [CW-1:0]     ch_idx;
    logic [CW-1:0]     ctx_raddr;
    ctx_t              ctx_rdata;
    ctx_t              ctx_cur;
    ctx_t              ctx_wdata;
    logic              ctx_we;
    logic [VAL_W-1:0]  smp_rdata;
    logic [AW-1:0]     smp_addr;
    logic [AW-1:0]     smp_waddr;
    logic              smp_we;
    logic [FILL_W-1:0] len;
    logic [FILL_W-1:0] head_c;
    logic              full;
    logic [FILL_W:0]   pos_sum;
    logic [FILL_W-1:0] pos;
    logic [FILL_W-1:0] slot;
    logic [FILL_W-1:0] head_inc;
    logic [SUM_W-1:0]  new_sum;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;
    logic              ld_out;

    assign in_ch  = s_tdata[CH_W-1:0];
    assign in_val = s_tdata[CH_W +: VAL_W];
    assign in_acc = s_tvalid && s_tready;

    assign ch_ok  = (32'(ch_reg) < CHANNELS);
    assign ch_idx = CW'(ch_reg);

    assign ctx_raddr = (state_reg == S_IDLE) ? CW'(in_ch) : ch_idx;
    assign ctx_cur   = ctx_vld_reg[ch_idx] ? ctx_rdata : '0;

    always_comb
    begin
        if (wl_reg == '0)
        begin
            len = FILL_W'(1);
        end
        else if (32'(wl_reg) > DEPTH)
        begin
            len = FILL_W'(DEPTH);
        end
        else
        begin
            len = wl_reg;
        end
    end

    assign head_c   = (32'(ctx_cur.head) >= DEPTH) ? '0 : ctx_cur.head;
    assign full     = (ctx_cur.fill >= len);
    assign pos_sum  = {1'b0, head_c} + {1'b0, ctx_cur.fill};
    assign pos      = (pos_sum >= {1'b0, len}) ? FILL_W'(pos_sum - {1'b0, len})
                                               : pos_sum[FILL_W-1:0];
    assign slot     = full ? head_c : pos;
    assign head_inc = head_c + 1'b1;
    assign smp_addr = AW'(32'(ch_idx) * DEPTH + 32'(slot));

    assign new_sum   = full_reg ? (sum_reg - {{(SUM_W-VAL_W){1'b0}}, smp_rdata}) : sum_reg;
    assign smp_waddr = addr_reg;

    always_comb
    begin
        if (state_reg == S_CTX)
        begin
            ctx_wdata = '0;
        end
        else
        begin
            ctx_wdata.sum  = new_sum;
            ctx_wdata.head = head_reg;
            ctx_wdata.fill = fill_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ctx_we     = 1'b0;
        smp_we     = 1'b0;
        div_start  = 1'b0;
        ld_out     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_CTX;
                end
            end
            S_CTX:
            begin
                if (!ch_ok)
                begin
                    state_next = S_FIN;
                end
                else if (cmd_reg == CMD_CLEAR)
                begin
                    ctx_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                ctx_we     = 1'b1;
                smp_we     = 1'b1;
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ld_out     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= WL_RESET;
            ctx_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wl_reg <= cfg_wdata;
            end
            if (ctx_we)
            begin
                ctx_vld_reg[ch_idx] <= 1'b1;
            end
            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg <= s_tuser;
            ch_reg  <= in_ch;
            val_reg <= in_val;
        end
        if (state_reg == S_CTX)
        begin
            full_reg      <= full;
            sum_reg       <= ctx_cur.sum + {{(SUM_W-VAL_W){1'b0}}, val_reg};
            head_reg      <= full ? ((head_inc >= len) ? '0 : head_inc) : ctx_cur.head;
            addr_reg      <= smp_addr;
            res_avg_reg   <= '0;
            res_empty_reg <= 1'b1;
            if (!ch_ok || (cmd_reg == CMD_CLEAR))
            begin
                fill_reg <= '0;
            end
            else
            begin
                fill_reg <= full ? ctx_cur.fill : ctx_cur.fill + 1'b1;
            end
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            res_avg_reg   <= div_quot[AVG_W-1:0];
            res_empty_reg <= 1'b0;
        end
        if (ld_out)
        begin
            out_avg_reg  <= res_avg_reg;
            out_st_reg   <= res_empty_reg ? ST_EMPTY : ST_OK;
            out_fill_reg <= fill_reg;
        end
    end

    rbma_ram #(
        .WIDTH($bits(ctx_t)),
        .DEPTH(CHANNELS),
        .AW   (CW)
    ) u_ctx_ram (
        .clk  (clk),
        .we   (ctx_we),
        .waddr(ch_idx),
        .wdata(ctx_wdata),
        .raddr(ctx_raddr),
        .rdata(ctx_rdata)
    );

    rbma_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CHANNELS * DEPTH),
        .AW   (AW)
    ) u_smp_ram (
        .clk  (clk),
        .we   (smp_we),
        .waddr(smp_waddr),
        .wdata(val_reg),
        .raddr(smp_addr),
        .rdata(smp_rdata)
    );

    rbma_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(new_sum),
        .divisor (fill_reg),
        .done    (div_done),
        .quotient(div_quot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-AVG_W-FILL_W){1'b0}}, out_fill_reg, out_avg_reg};
    assign m_tuser  = out_st_reg;

    a_accept_reads_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_CTX))
        else $error("accepted beat did not start a context read");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (fill_reg != '0))
        else $error("divider started with zero fill level");

    a_status_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ST_EMPTY) == (m_tdata[AVG_W +: FILL_W] == '0)))
        else $error("status disagrees with fill count");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!ctx_we && !smp_we))
        else $error("memory write while idle");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the ring buffer moving average block. A directed
// table covers value extremes, clears and empty channels. Random phases then
// sweep window_length through its extremes, including out-of-range settings
// and changes made without clearing the channels. Each result beat is
// compared with an in-order queue of expected results, given by the directed
// table where a row holds them and else by an internal per-channel ring model.
// ----------------------------------------------------------------------------
module tb;
    import rbma_pkg::*;

    localparam int DEPTH    = DEF_DEPTH;
    localparam int CHANNELS = DEF_CHANNELS;
    localparam int LIMIT    = 200000;
    localparam int PHASES   = 10;
    localparam int PHASE_N  = 37;
    localparam int HOLD_LEN = 400;

    typedef struct {
        logic [AVG_W-1:0]  average;
        logic              status;
        logic [FILL_W-1:0] fill_count;
    } avg_result_t;

    typedef struct {
        logic              cmd;
        logic [CH_W-1:0]   ch;
        logic [VAL_W-1:0]  val;
        bit                typed;
        logic [AVG_W-1:0]  average;
        logic              status;
        logic [FILL_W-1:0] fill_count;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [WL_W-1:0]      cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    logic [VAL_W-1:0]  sample_mem [CHANNELS][DEPTH];
    bit                sample_written [CHANNELS][DEPTH];
    logic [SUM_W-1:0]  ring_sum [CHANNELS];
    int unsigned       ring_head [CHANNELS];
    int unsigned       ring_fill [CHANNELS];
    logic [WL_W-1:0]   win_len;

    avg_result_t avg_expect_q[$];
    int          err_count;
    int          cycle_cnt;
    bit          hold_req;
    bit          no_idle;

    ring_buffer_moving_average #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int unsigned eff_window();
        int unsigned len;
        len = win_len;
        if (len == 0)
            len = 1;
        if (len > DEPTH)
            len = DEPTH;
        return len;
    endfunction

    function automatic int unsigned head_slot(int unsigned ch);
        return (ring_head[ch] >= DEPTH) ? 0 : ring_head[ch];
    endfunction

    // a full push would read a slot that was never written
    function automatic bit stale_read(int unsigned ch);
        return ring_fill[ch] >= eff_window() && !sample_written[ch][head_slot(ch)];
    endfunction

    function automatic avg_result_t mavg_update(logic cmd, logic [CH_W-1:0] ch,
                                               logic [VAL_W-1:0] val);
        avg_result_t      r;
        int unsigned      len;
        int unsigned      head;
        int unsigned      fill;
        int unsigned      pos;
        logic [SUM_W-1:0] quo;
        r.average    = '0;
        r.status     = ST_EMPTY;
        r.fill_count = '0;
        if (cmd == CMD_CLEAR)
        begin
            ring_fill[ch] = 0;
            ring_head[ch] = 0;
            ring_sum[ch]  = '0;
            return r;
        end
        len  = eff_window();
        head = head_slot(ch);
        fill = ring_fill[ch];
        if (fill >= len)
        begin
            ring_sum[ch] = ring_sum[ch] - SUM_W'(sample_mem[ch][head]) + SUM_W'(val);
            sample_mem[ch][head] = val;
            head = head + 1;
            if (head >= len)
                head = 0;
            ring_head[ch] = head;
        end
        else
        begin
            pos = (head + fill) % len;
            sample_mem[ch][pos]     = val;
            sample_written[ch][pos] = 1'b1;
            ring_sum[ch]  = ring_sum[ch] + SUM_W'(val);
            ring_fill[ch] = fill + 1;
        end
        fill = ring_fill[ch];
        if (fill == 0)
            return r;
        quo          = ring_sum[ch] / SUM_W'(fill);
        r.average    = quo[AVG_W-1:0];
        r.status     = ST_OK;
        r.fill_count = FILL_W'(fill);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(0, 255));
            3: return 32'hFFFF_FF00 | VAL_W'($urandom_range(0, 255));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(logic cmd, logic [CH_W-1:0] ch, logic [VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, ch});
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic run_item(logic cmd, logic [CH_W-1:0] ch, logic [VAL_W-1:0] val);
        avg_expect_q.push_back(mavg_update(cmd, ch, val));
        send_beat(cmd, ch, val);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (avg_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_window(logic [WL_W-1:0] wl);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wl;
        @(negedge clk);
        cfg_we    <= 1'b0;
        win_len = wl;
    endtask

    // expect results
    always @(posedge clk)
    begin
        avg_result_t e;
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (avg_expect_q.size() == 0)
            begin
                $error("result beat with no expectation: tdata %0h status %0b",
                       m_tdata, m_tuser);
                err_count++;
            end
            else
            begin
                e = avg_expect_q.pop_front();
                if (m_tdata[AVG_W-1:0] !== e.average)
                begin
                    $error("average mismatch: expected %0h, got %0h",
                           e.average, m_tdata[AVG_W-1:0]);
                    err_count++;
                end
                if (m_tdata[AVG_W+FILL_W-1:AVG_W] !== e.fill_count)
                begin
                    $error("fill_count mismatch: expected %0d, got %0d",
                           e.fill_count, m_tdata[AVG_W+FILL_W-1:AVG_W]);
                    err_count++;
                end
                if (m_tuser !== e.status)
                begin
                    $error("status mismatch: expected %0b, got %0b", e.status, m_tuser);
                    err_count++;
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        dir_row_t        rows[$];
        avg_result_t     r;
        logic [WL_W-1:0] wl_plan[PHASES];
        bit              clear_plan[PHASES];
        logic [WL_W-1:0] wl;
        logic [CH_W-1:0] focus;
        logic [CH_W-1:0] ch;
        logic            cmd;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PUSH;
        err_count = 0;
        cycle_cnt = 0;
        hold_req  = 1'b0;
        no_idle   = 1'b0;
        win_len   = WL_RESET;
        for (int c = 0; c < CHANNELS; c++)
        begin
            ring_sum[c]  = '0;
            ring_head[c] = 0;
            ring_fill[c] = 0;
            for (int d = 0; d < DEPTH; d++)
            begin
                sample_mem[c][d]     = '0;
                sample_written[c][d] = 1'b0;
            end
        end

        rows = '{
            '{CMD_PUSH,  3'd0, 32'h0000_0000, 1, 32'h0000_0000, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd0, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, ST_OK,    5'd2},
            '{CMD_PUSH,  3'd0, 32'hFFFF_FFFF, 0, 32'h0,         ST_OK,    5'd0},
            '{CMD_CLEAR, 3'd0, 32'h1234_5678, 1, 32'h0000_0000, ST_EMPTY, 5'd0},
            '{CMD_CLEAR, 3'd7, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_EMPTY, 5'd0},
            '{CMD_PUSH,  3'd7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd7, 32'h0000_0001, 1, 32'h8000_0000, ST_OK,    5'd2},
            '{CMD_PUSH,  3'd1, 32'h0000_0001, 1, 32'h0000_0001, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd2, 32'h8000_0000, 1, 32'h8000_0000, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd2, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, ST_OK,    5'd2},
            '{CMD_PUSH,  3'd3, 32'h5555_5555, 1, 32'h5555_5555, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd4, 32'hAAAA_AAAA, 1, 32'hAAAA_AAAA, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd5, 32'h1234_5678, 0, 32'h0,         ST_OK,    5'd0},
            '{CMD_PUSH,  3'd6, 32'hC0DE_F00D, 0, 32'h0,         ST_OK,    5'd0},
            '{CMD_PUSH,  3'd5, 32'h0000_0009, 0, 32'h0,         ST_OK,    5'd0},
            '{CMD_CLEAR, 3'd5, 32'h0000_0000, 1, 32'h0000_0000, ST_EMPTY, 5'd0},
            '{CMD_PUSH,  3'd5, 32'h0000_0064, 1, 32'h0000_0064, ST_OK,    5'd1},
            '{CMD_PUSH,  3'd6, 32'h0000_0001, 0, 32'h0,         ST_OK,    5'd0},
            '{CMD_CLEAR, 3'd1, 32'hFFFF_FFFF, 1, 32'h0000_0000, ST_EMPTY, 5'd0},
            '{CMD_CLEAR, 3'd1, 32'h0000_0000, 1, 32'h0000_0000, ST_EMPTY, 5'd0}
        };

        wl_plan    = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd5, 5'd12, 5'd0, 5'd3};
        clear_plan = '{1, 1, 1, 1, 1, 1, 0, 0, 1, 1};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            r = mavg_update(rows[i].cmd, rows[i].ch, rows[i].val);
            if (rows[i].typed)
            begin
                r.average    = rows[i].average;
                r.status     = rows[i].status;
                r.fill_count = rows[i].fill_count;
            end
            avg_expect_q.push_back(r);
            send_beat(rows[i].cmd, rows[i].ch, rows[i].val);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            wl = (p == 8) ? WL_W'($urandom_range(0, 31)) : wl_plan[p];
            write_window(wl);
            no_idle = (p == 4);
            if (clear_plan[p])
                for (int c = 0; c < CHANNELS; c++)
                    run_item(CMD_CLEAR, CH_W'(c), rand_value());
            if (p == 3)
                hold_req = 1'b1;
            focus = CH_W'($urandom_range(0, CHANNELS - 1));
            for (int n = 0; n < PHASE_N; n++)
            begin
                cmd = ($urandom_range(0, 99) < 8) ? CMD_CLEAR : CMD_PUSH;
                ch  = $urandom_range(0, 1) ? focus : CH_W'($urandom_range(0, CHANNELS - 1));
                if (cmd == CMD_PUSH && stale_read(ch))
                    cmd = CMD_CLEAR;
                run_item(cmd, ch, rand_value());
            end
            no_idle = 1'b0;
        end

        drain();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
